// File: design/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Command and character codes, operation kinds and the operation record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Command codes of the input channel.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Control characters recognized by the put command, and the space used for blank cells.
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Cell written everywhere by the clearing pass after reset.
  localparam logic [15:0] RESET_CELL = 16'h0720;

  // Widest row and column indexes over the supported screen sizes.
  localparam int unsigned ROW_MAX_W = 6;
  localparam int unsigned COL_MAX_W = 7;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_SET,
    OP_READ
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [7:0]             ch;
    logic [ROW_MAX_W-1:0]   row;
    logic [COL_MAX_W-1:0]   col;
  } op_t;

endpackage

// File: design/tcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console front end
// Accepts command transactions, classifies them into operation kinds and
// clamps the target row and column before they enter the queue.
// ----------------------------------------------------------------------------
module tcc_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [7:0]       character_i,
  input  logic [6:0]       target_row_i,
  input  logic [7:0]       target_col_i,
  input  logic             q_full_i,
  input  logic             init_busy_i,
  output logic             push_o,
  output tcc_pkg::op_t     op_o
);

  localparam logic [6:0] ROW_LIM = 7'(ROWS - 1);
  localparam logic [7:0] COL_LIM = 8'(COLUMNS - 1);

  logic [6:0] row_c;
  logic [7:0] col_c;

  // Negative targets go to zero, large ones to the last row or column.
  always_comb begin
    if (target_row_i[6]) begin
      row_c = '0;
    end else if ({1'b0, target_row_i[5:0]} > ROW_LIM) begin
      row_c = ROW_LIM;
    end else begin
      row_c = {1'b0, target_row_i[5:0]};
    end
    if (target_col_i[7]) begin
      col_c = '0;
    end else if ({1'b0, target_col_i[6:0]} > COL_LIM) begin
      col_c = COL_LIM;
    end else begin
      col_c = {1'b0, target_col_i[6:0]};
    end
  end

  always_comb begin
    op_o.ch  = character_i;
    op_o.row = row_c[tcc_pkg::ROW_MAX_W-1:0];
    op_o.col = col_c[tcc_pkg::COL_MAX_W-1:0];
    unique case (command_i)
      tcc_pkg::CMD_PUT: begin
        unique case (character_i)
          tcc_pkg::CH_NEWLINE:   op_o.kind = tcc_pkg::OP_NEWLINE;
          tcc_pkg::CH_RETURN:    op_o.kind = tcc_pkg::OP_RETURN;
          tcc_pkg::CH_BACKSPACE: op_o.kind = tcc_pkg::OP_BACKSPACE;
          default:               op_o.kind = tcc_pkg::OP_PRINT;
        endcase
      end
      tcc_pkg::CMD_CLEAR: op_o.kind = tcc_pkg::OP_CLEAR;
      tcc_pkg::CMD_SET:   op_o.kind = tcc_pkg::OP_SET;
      default:            op_o.kind = tcc_pkg::OP_READ;
    endcase
  end

  assign in_stall_o = q_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

endmodule

// File: design/tcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console operation queue
// Two-entry queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module tcc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcc_pkg::op_t  op_i,
  output logic          full_o,
  output logic          valid_o,
  output tcc_pkg::op_t  op_o,
  input  logic          pop_i
);

  localparam int unsigned DEPTH = 2;

  tcc_pkg::op_t entry_q [DEPTH];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o  = (count_q == 2'(DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign op_o    = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= op_i;
    end
  end

endmodule

// File: design/tcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console back end
// Owns the screen memory and the cursor, carries out operations from the
// queue (including scroll and clear sweeps) and drives the result register.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    attr_i,
  input  logic          q_valid_i,
  input  tcc_pkg::op_t  q_op_i,
  output logic          q_pop_o,
  output logic          init_busy_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [4:0]    cursor_row_o,
  output logic [6:0]    cursor_col_o,
  output logic [10:0]   cursor_position_o,
  output logic [7:0]    cell_char_o,
  output logic [7:0]    cell_attr_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = (AW > 11) ? AW : 11;
  localparam int unsigned RXW   = (RW > 5) ? RW : 5;
  localparam int unsigned CXW   = (CW > 7) ? CW : 7;

  localparam logic [AW-1:0] ADDR_LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] ADDR_BOTTOM = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ADDR_COLS   = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          is_read_q, is_read_d;
  logic          pend_q;
  logic [AW-1:0] wa_q;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          out_valid_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic [10:0]   out_pos_q;
  logic [15:0]   out_cell_q;

  logic          slot_free;
  logic          load;
  logic          last_row;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] head_addr;
  logic [15:0]   blank;
  logic [PW-1:0] pos_x;
  logic [RXW-1:0] row_x;
  logic [CXW-1:0] col_x;

  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign last_row  = (row_q == ROW_LAST);
  assign blank     = {attr_i, tcc_pkg::CH_SPACE};
  assign cur_addr  = AW'(row_q) * ADDR_COLS + AW'(col_q);
  assign head_addr = AW'(q_op_i.row[RW-1:0]) * ADDR_COLS + AW'(q_op_i.col[CW-1:0]);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    rd_addr_d = rd_addr_q;
    is_read_d = is_read_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = blank;
    mem_raddr = rd_addr_q;
    // During a scroll, each row cell read last cycle is written one row up.
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wa_q;
      mem_wdata = rdata_q;
    end
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcc_pkg::RESET_CELL;
        if (cnt_q == ADDR_LAST) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        mem_raddr = head_addr;
        if (q_valid_i && slot_free) begin
          q_pop_o   = 1'b1;
          is_read_d = 1'b0;
          unique case (q_op_i.kind)
            tcc_pkg::OP_NEWLINE: begin
              col_d = '0;
              if (last_row) begin
                state_d = S_SCROLL;
                cnt_d   = ADDR_COLS;
              end else begin
                row_d = row_q + RW'(1);
                load  = 1'b1;
              end
            end
            tcc_pkg::OP_RETURN: begin
              col_d = '0;
              load  = 1'b1;
            end
            tcc_pkg::OP_BACKSPACE: begin
              if (col_q != '0) begin
                col_d     = col_q - CW'(1);
                mem_we    = 1'b1;
                mem_waddr = cur_addr - AW'(1);
                mem_wdata = blank;
              end
              load = 1'b1;
            end
            tcc_pkg::OP_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr_i, q_op_i.ch};
              if (col_q == COL_LAST) begin
                col_d = '0;
                if (last_row) begin
                  state_d = S_SCROLL;
                  cnt_d   = ADDR_COLS;
                end else begin
                  row_d = row_q + RW'(1);
                  load  = 1'b1;
                end
              end else begin
                col_d = col_q + CW'(1);
                load  = 1'b1;
              end
            end
            tcc_pkg::OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              state_d = S_FILL;
            end
            tcc_pkg::OP_SET: begin
              row_d = q_op_i.row[RW-1:0];
              col_d = q_op_i.col[CW-1:0];
              load  = 1'b1;
            end
            tcc_pkg::OP_READ: begin
              rd_addr_d = head_addr;
              is_read_d = 1'b1;
              state_d   = S_EMIT;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_SCROLL: begin
        mem_raddr = cnt_q;
        if (cnt_q == ADDR_LAST) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_DRAIN: begin
        cnt_d   = ADDR_BOTTOM;
        state_d = S_FILL;
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (cnt_q == ADDR_LAST) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign pos_x = PW'(row_d) * PW'(COLUMNS) + PW'(col_d);
  assign row_x = RXW'(row_d);
  assign col_x = CXW'(col_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      rd_addr_q   <= '0;
      is_read_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      rd_addr_q   <= rd_addr_d;
      is_read_q   <= is_read_d;
      pend_q      <= (state_q == S_SCROLL);
      out_valid_q <= load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= cnt_q - ADDR_COLS;
    if (load) begin
      out_row_q  <= row_x[4:0];
      out_col_q  <= col_x[6:0];
      out_pos_q  <= pos_x[10:0];
      out_cell_q <= is_read_d ? rdata_q : 16'h0000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign init_busy_o       = (state_q == S_INIT);
  assign out_valid_o       = out_valid_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_position_o = out_pos_q;
  assign cell_char_o       = out_cell_q[7:0];
  assign cell_attr_o       = out_cell_q[15:8];

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_LAST) && (col_q <= COL_LAST))
    else $error("cursor left the screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (row_q == ROW_LAST))
    else $error("scroll finished with cursor off the last row");

  a_emit_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !mem_we)
    else $error("screen written while a result waits");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (!out_valid_q && !q_pop_o))
    else $error("activity during the clearing pass");
`endif

endmodule

// File: design/text_console_cursor_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell console with cursor, scrolling, clear, set cursor and
// cell read, behind a command channel, a result channel and an APB port.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells and
// stalls its input until that pass ends; register writes are taken
// throughout. Commands are queued two deep, and the back end works on one at
// a time through a screen memory with one read and one write port: clear
// screen and a put or newline that scrolls sweep the whole screen, since
// every cell is moved or filled through the one write port.
// Each command gives exactly one result transaction; the colour registers
// are meant to be changed only while no command is in flight.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  character_i,
  input  logic [6:0]  target_row_i,
  input  logic [7:0]  target_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [10:0] cursor_position_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]   fg_q;
  logic [3:0]   bg_q;
  logic         cfg_we;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;
  logic         push;
  logic         init_busy;
  tcc_pkg::op_t front_op;
  tcc_pkg::op_t head_op;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'h7;
      bg_q <= 4'h0;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        bg_q <= pwdata[3:0];
      end else begin
        fg_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'h0, bg_q} : {28'h0, fg_q};

  tcc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .character_i  (character_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .q_full_i     (q_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .op_o         (front_op)
  );

  tcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (head_op),
    .pop_i   (q_pop)
  );

  tcc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .attr_i            ({bg_q, fg_q}),
    .q_valid_i         (q_valid),
    .q_op_i            (head_op),
    .q_pop_o           (q_pop),
    .init_busy_o       (init_busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_row_o      (cursor_row_o),
    .cursor_col_o      (cursor_col_o),
    .cursor_position_o (cursor_position_o),
    .cell_char_o       (cell_char_o),
    .cell_attr_o       (cell_attr_o)
  );

endmodule
